// ===== design/afs_pkg.sv =====
package afs_pkg;

  // Table geometry
  localparam int MaxFrames = 16;
  localparam int FrameW    = $clog2(MaxFrames);

  // Field widths
  localparam int CountW    = 5;
  localparam int DurW      = 16;
  localparam int TickW     = 16;
  localparam int SpeedW    = 12;
  localparam int CfgDataW  = 12;
  localparam int OutTimeW  = 16;

  // Elapsed time is signed with FracW fraction bits
  localparam int FracW     = 8;
  localparam int ElapsedW  = 32;

  // Sum of all durations in whole time units
  localparam int TotalW    = DurW + FrameW;
  // Whole-unit part of a non-negative elapsed value
  localparam int DvdW      = ElapsedW - 1 - FracW;
  localparam int ModCntW   = $clog2(DvdW);
  localparam int RemW      = TotalW + FracW;
  // Unsigned tick times signed speed
  localparam int ProdW     = TickW + 1 + SpeedW;

  localparam logic signed [SpeedW-1:0] SpeedReset = SpeedW'(256);

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncTick  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CfgFrameCount = 2'd0,
    CfgLoopEnable = 2'd1,
    CfgPlaying    = 2'd2,
    CfgSpeed      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [3:0]        duration_index;
    logic [DurW-1:0]   duration_value;
    logic [TickW-1:0]  tick_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          frame_index;
    logic [OutTimeW-1:0] elapsed_time;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;
    logic cap_tick;
    logic clamp;
    logic mul;
    logic add;
    logic cnt_clr;
    logic sum_acc;
    logic rd_en;
    logic rd_frame;
    logic f_inc;
    logic f_dec;
    logic f_zero;
    logic f_last;
    logic e_sub_d;
    logic e_add_d;
    logic e_set_d;
    logic e_clr;
    logic mod_start;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run;
    logic backward;
    logic loop;
    logic cnt_last;
    logic d_nz;
    logic e_lt_d;
    logic f_lt_last;
    logic f_nz;
    logic e_neg;
    logic d0_nz;
    logic e_lt_neg_t;
    logic mod_done;
  } status_t;

endpackage

// ===== design/afs_mod.sv =====
module afs_mod (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [afs_pkg::ElapsedW-2:0]        value,
  input  logic [afs_pkg::TotalW-1:0]          divisor,
  output logic                                done,
  output logic [afs_pkg::RemW-1:0]            rem_q8
);

  logic                          busy;
  logic [afs_pkg::ModCntW-1:0]   cnt;
  logic [afs_pkg::DvdW-1:0]      dvd;
  logic [afs_pkg::FracW-1:0]     frac;
  logic [afs_pkg::TotalW-1:0]    div;
  logic [afs_pkg::TotalW-1:0]    rem;
  logic [afs_pkg::TotalW:0]      shifted;
  logic [afs_pkg::TotalW:0]      diff;
  logic [afs_pkg::TotalW-1:0]    rem_next;

  // Divisor is whole units, so the fraction bits pass through untouched
  assign shifted  = {rem, dvd[afs_pkg::DvdW-1]};
  assign diff     = shifted - {1'b0, div};
  assign rem_next = diff[afs_pkg::TotalW] ? shifted[afs_pkg::TotalW-1:0]
                                          : diff[afs_pkg::TotalW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= afs_pkg::ModCntW'(afs_pkg::DvdW - 1);
      dvd  <= value[afs_pkg::ElapsedW-2:afs_pkg::FracW];
      frac <= value[afs_pkg::FracW-1:0];
      div  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dvd <= {dvd[afs_pkg::DvdW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rem_q8 = {rem, frac};

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit restarted while busy");
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(afs_pkg::DvdW + 1) done)
    else $error("remainder unit latency wrong");

endmodule

// ===== design/afs_dpath.sv =====
module afs_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  afs_pkg::in_item_t                in_data,
  input  logic                             cfg_valid,
  input  afs_pkg::cfg_idx_t                cfg_index,
  input  logic [afs_pkg::CfgDataW-1:0]     cfg_data,
  input  afs_pkg::cmd_t                    cmd,
  output afs_pkg::status_t                 status,
  output afs_pkg::out_item_t               out_data
);

  // Configuration
  logic [afs_pkg::CountW-1:0]         frames_used;
  logic                               loop_enable;
  logic                               playing;
  logic signed [afs_pkg::SpeedW-1:0]  speed;

  // Playback state
  logic [afs_pkg::FrameW-1:0]         frame;
  logic signed [afs_pkg::ElapsedW-1:0] elapsed;
  logic signed [afs_pkg::ElapsedW-1:0] elapsed_next;

  // Working registers
  logic [afs_pkg::TickW-1:0]          tick;
  logic signed [afs_pkg::ProdW-1:0]   prod;
  logic [afs_pkg::FrameW-1:0]         cnt;
  logic [afs_pkg::TotalW-1:0]         total;
  logic                               d0_nz;
  logic [afs_pkg::DurW-1:0]           rd_data;
  logic [afs_pkg::DurW-1:0]           dur_mem [afs_pkg::MaxFrames];

  logic [afs_pkg::CountW-1:0]         n_eff;
  logic [afs_pkg::CountW-1:0]         n_last;
  logic [afs_pkg::FrameW-1:0]         rd_addr;
  logic signed [afs_pkg::ElapsedW-1:0] dq;
  logic [afs_pkg::ElapsedW-1:0]       tq;
  logic signed [afs_pkg::ElapsedW:0]  sat_sum;
  logic [afs_pkg::ElapsedW:0]         neg_t_sum;
  logic [afs_pkg::ElapsedW-2:0]       mod_value;
  logic                               mod_done;
  logic [afs_pkg::RemW-1:0]           mod_rem;
  logic [afs_pkg::ElapsedW-1:0]       mod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_used <= '0;
      loop_enable <= 1'b0;
      playing     <= 1'b0;
      speed       <= afs_pkg::SpeedReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afs_pkg::CfgFrameCount: frames_used <= cfg_data[afs_pkg::CountW-1:0];
        afs_pkg::CfgLoopEnable: loop_enable <= cfg_data[0];
        afs_pkg::CfgPlaying:    playing     <= cfg_data[0];
        afs_pkg::CfgSpeed:      speed       <= $signed(cfg_data[afs_pkg::SpeedW-1:0]);
        default:                ;
      endcase
    end
  end

  assign n_eff  = (frames_used > afs_pkg::CountW'(afs_pkg::MaxFrames))
                  ? afs_pkg::CountW'(afs_pkg::MaxFrames) : frames_used;
  assign n_last = n_eff - 1'b1;

  // Duration store, one read port with registered data
  assign rd_addr = cmd.rd_frame ? frame : cnt;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      dur_mem[afs_pkg::FrameW'(in_data.duration_index)] <= in_data.duration_value;
    end
    if (cmd.rd_en) begin
      rd_data <= dur_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_tick) begin
      tick <= in_data.tick_time;
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, tick}) * speed;
    end
    if (cmd.cnt_clr) begin
      cnt   <= '0;
      total <= '0;
    end else if (cmd.sum_acc) begin
      cnt   <= cnt + 1'b1;
      total <= total + afs_pkg::TotalW'(rd_data);
      if (cnt == '0) begin
        d0_nz <= (rd_data != '0);
      end
    end
  end

  // Duration and total scaled to the elapsed format
  assign dq = $signed({(afs_pkg::ElapsedW - afs_pkg::DurW - afs_pkg::FracW)'(0),
                       rd_data, afs_pkg::FracW'(0)});
  assign tq = {(afs_pkg::ElapsedW - afs_pkg::TotalW - afs_pkg::FracW)'(0),
               total, afs_pkg::FracW'(0)};

  assign sat_sum = {elapsed[afs_pkg::ElapsedW-1], elapsed}
                 + {{(afs_pkg::ElapsedW + 1 - afs_pkg::ProdW){prod[afs_pkg::ProdW-1]}}, prod};
  assign neg_t_sum = {elapsed[afs_pkg::ElapsedW-1], elapsed} + {1'b0, tq};

  // Backward reduction works on -e-1, which is the bitwise inverse
  assign mod_value = speed[afs_pkg::SpeedW-1] ? ~elapsed[afs_pkg::ElapsedW-2:0]
                                               : elapsed[afs_pkg::ElapsedW-2:0];
  assign mod_ext   = {(afs_pkg::ElapsedW - afs_pkg::RemW)'(0), mod_rem};

  afs_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mod_start),
    .value   (mod_value),
    .divisor (total),
    .done    (mod_done),
    .rem_q8  (mod_rem)
  );

  always_comb begin
    elapsed_next = elapsed;
    if (cmd.add) begin
      if (sat_sum[afs_pkg::ElapsedW] != sat_sum[afs_pkg::ElapsedW-1]) begin
        elapsed_next = sat_sum[afs_pkg::ElapsedW]
                       ? {1'b1, {(afs_pkg::ElapsedW-1){1'b0}}}
                       : {1'b0, {(afs_pkg::ElapsedW-1){1'b1}}};
      end else begin
        elapsed_next = sat_sum[afs_pkg::ElapsedW-1:0];
      end
    end else if (cmd.e_sub_d) begin
      elapsed_next = elapsed - dq;
    end else if (cmd.e_add_d) begin
      elapsed_next = elapsed + dq;
    end else if (cmd.e_set_d) begin
      elapsed_next = dq;
    end else if (cmd.e_clr) begin
      elapsed_next = '0;
    end else if (mod_done) begin
      elapsed_next = speed[afs_pkg::SpeedW-1] ? $signed(~mod_ext) : $signed(mod_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame   <= '0;
      elapsed <= '0;
    end else begin
      elapsed <= elapsed_next;
      if (cmd.clamp) begin
        if (n_eff == '0) begin
          frame <= '0;
        end else if (afs_pkg::CountW'(frame) >= n_eff) begin
          frame <= n_last[afs_pkg::FrameW-1:0];
        end
      end else if (cmd.f_inc) begin
        frame <= frame + 1'b1;
      end else if (cmd.f_dec) begin
        frame <= frame - 1'b1;
      end else if (cmd.f_zero) begin
        frame <= '0;
      end else if (cmd.f_last) begin
        frame <= n_last[afs_pkg::FrameW-1:0];
      end
    end
  end

  // Result register: negative time reads as zero, large time saturates
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.frame_index <= 4'(frame);
      if (elapsed[afs_pkg::ElapsedW-1]) begin
        out_data.elapsed_time <= '0;
      end else if (|elapsed[afs_pkg::ElapsedW-2:afs_pkg::FracW+afs_pkg::OutTimeW]) begin
        out_data.elapsed_time <= '1;
      end else begin
        out_data.elapsed_time <= elapsed[afs_pkg::FracW+afs_pkg::OutTimeW-1:afs_pkg::FracW];
      end
    end
  end

  assign status.run        = playing && (n_eff != '0) && (speed != '0);
  assign status.backward   = speed[afs_pkg::SpeedW-1];
  assign status.loop       = loop_enable;
  assign status.cnt_last   = (afs_pkg::CountW'(cnt) == n_last);
  assign status.d_nz       = (rd_data != '0);
  assign status.e_lt_d     = (elapsed < dq);
  assign status.f_lt_last  = (afs_pkg::CountW'(frame) < n_last);
  assign status.f_nz       = (frame != '0);
  assign status.e_neg      = elapsed[afs_pkg::ElapsedW-1];
  assign status.d0_nz      = d0_nz;
  assign status.e_lt_neg_t = neg_t_sum[afs_pkg::ElapsedW];
  assign status.mod_done   = mod_done;

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd.clamp |=> (afs_pkg::CountW'(frame) < $past(n_eff))
               || (frame == '0 && $past(n_eff) == '0))
    else $error("frame outside the frames in use after clamp");

endmodule

// ===== design/afs_ctrl.sv =====
module afs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  afs_pkg::func_t     in_func,
  output logic               out_valid,
  input  logic               out_ready,
  output afs_pkg::cmd_t      cmd,
  input  afs_pkg::status_t   status
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'b0_0000_0000_0000_0001,
    S_CLAMP    = 17'b0_0000_0000_0000_0010,
    S_MUL      = 17'b0_0000_0000_0000_0100,
    S_ADD      = 17'b0_0000_0000_0000_1000,
    S_SUM_RD   = 17'b0_0000_0000_0001_0000,
    S_SUM_ACC  = 17'b0_0000_0000_0010_0000,
    S_F_RD     = 17'b0_0000_0000_0100_0000,
    S_F_STEP   = 17'b0_0000_0000_1000_0000,
    S_B_CHK    = 17'b0_0000_0001_0000_0000,
    S_B_RD     = 17'b0_0000_0010_0000_0000,
    S_B_ADD    = 17'b0_0000_0100_0000_0000,
    S_BW_RD    = 17'b0_0000_1000_0000_0000,
    S_BW_ADD   = 17'b0_0001_0000_0000_0000,
    S_BW_CHK   = 17'b0_0010_0000_0000_0000,
    S_MOD_GO   = 17'b0_0100_0000_0000_0000,
    S_MOD_WAIT = 17'b0_1000_0000_0000_0000,
    S_OUT      = 17'b1_0000_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_func == afs_pkg::FuncWrite) begin
            cmd.wr_en  = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.cap_tick = 1'b1;
            state_next   = S_CLAMP;
          end
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = status.run ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add     = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = S_SUM_RD;
      end
      S_SUM_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (status.cnt_last) begin
          state_next = status.backward ? S_B_CHK : S_F_RD;
        end else begin
          state_next = S_SUM_RD;
        end
      end
      S_F_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_frame = 1'b1;
        state_next   = S_F_STEP;
      end
      S_F_STEP: begin
        priority if (status.d_nz && status.e_lt_d) begin
          state_next = S_OUT;
        end else if (status.f_lt_last) begin
          cmd.e_sub_d = status.d_nz;
          cmd.f_inc   = 1'b1;
          state_next  = S_F_RD;
        end else if (status.loop) begin
          if (status.d_nz) begin
            cmd.e_sub_d = 1'b1;
            cmd.f_zero  = 1'b1;
            state_next  = S_MOD_GO;
          end else begin
            state_next = S_OUT;
          end
        end else begin
          cmd.e_set_d = status.d_nz;
          state_next  = S_OUT;
        end
      end
      S_B_CHK: begin
        priority if (!status.e_neg) begin
          state_next = S_OUT;
        end else if (status.f_nz) begin
          cmd.f_dec  = 1'b1;
          state_next = S_B_RD;
        end else if (status.loop) begin
          if (status.d0_nz) begin
            cmd.f_last = 1'b1;
            state_next = S_BW_RD;
          end else begin
            state_next = S_OUT;
          end
        end else begin
          cmd.e_clr  = 1'b1;
          state_next = S_OUT;
        end
      end
      S_B_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_frame = 1'b1;
        state_next   = S_B_ADD;
      end
      S_B_ADD: begin
        cmd.e_add_d = 1'b1;
        state_next  = S_B_CHK;
      end
      S_BW_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_frame = 1'b1;
        state_next   = S_BW_ADD;
      end
      S_BW_ADD: begin
        cmd.e_add_d = 1'b1;
        state_next  = S_BW_CHK;
      end
      S_BW_CHK: begin
        state_next = status.e_lt_neg_t ? S_MOD_GO : S_B_CHK;
      end
      S_MOD_GO: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (status.mod_done) begin
          state_next = status.backward ? S_B_CHK : S_F_RD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.mod_done |-> state == S_MOD_WAIT)
    else $error("remainder result arrived outside its wait state");
  a_out_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (state == S_IDLE && out_valid))
    else $error("finished result not handed to the output register");

endmodule

// ===== design/animation_frame_sequencer_core.sv =====
// Sprite animation sequencer. Holds a table of frame durations (whole time
// units, zero marks a frame to skip), a current frame and a signed elapsed
// time with 8 fraction bits. An input word with func = write stores one
// duration; func = tick clamps the frame to the frames in use, and while
// playing advances elapsed time by tick_time * speed (saturating) and walks
// forward or backward over the durations, wrapping when looping or stopping
// at the ends. Every input word yields exactly one result word: the frame and
// the whole part of the elapsed time, clamped to 0..65535. One word is in
// flight at a time; in_ready is high only while the block is idle. A playing
// tick sums the duration table through its single read port, then steps
// frame by frame forward or backward; every forward wrap and every backward
// wrap that has whole passes to fold waits on the remainder unit, which
// retires one quotient bit per cycle. A finished result waits in the
// output register until taken. The configuration port is always ready;
// write it only while no word is in flight. Durations read before they
// were ever written are undefined.
module animation_frame_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  afs_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output afs_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  afs_pkg::cfg_idx_t               cfg_index,
  input  logic [afs_pkg::CfgDataW-1:0]    cfg_data
);

  afs_pkg::cmd_t    cmd;
  afs_pkg::status_t status;

  // Each config word is a plain register write, so never stall it
  assign cfg_ready = 1'b1;

  // Sequence the walk: one state per table read, add or remainder wait
  afs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Hold the table, playback state, config registers and result register
  afs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WalkLimit = 4 * afs_pkg::MaxFrames + 8;
  localparam longint ElapsedMax = 64'sd2147483647;
  localparam longint ElapsedMin = -ElapsedMax - 1;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  afs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  afs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  afs_pkg::cfg_idx_t cfg_index = afs_pkg::CfgFrameCount;
  logic [afs_pkg::CfgDataW-1:0] cfg_data = '0;

  // Mirror of the block's registers and state
  logic [afs_pkg::CountW-1:0] cfg_count = '0;
  logic cfg_loop = 1'b0;
  logic cfg_play = 1'b0;
  logic signed [afs_pkg::SpeedW-1:0] cfg_speed = afs_pkg::SpeedReset;
  int unsigned cur_frame = 0;
  int elapsed_q = 0;
  logic [afs_pkg::DurW-1:0] durations [afs_pkg::MaxFrames];

  afs_pkg::out_item_t due_results [$];
  afs_pkg::out_item_t want_word;
  int fail_count = 0;
  bit idle_on = 1'b1;
  bit hold_flag = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  animation_frame_sequencer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Duration of frame f in Q.8; frames beyond the table count as zero
  function automatic longint dur_fx(int unsigned f);
    if (f >= afs_pkg::MaxFrames) return 0;
    return longint'(durations[f]) <<< afs_pkg::FracW;
  endfunction

  // Length of one full pass over the first n frames, Q.8
  function automatic longint pass_fx(int unsigned n);
    longint t;
    t = 0;
    for (int unsigned i = 0; i < n; i++) t += dur_fx(i);
    return t;
  endfunction

  // Apply one input word to the mirrored state and return the result word
  function automatic afs_pkg::out_item_t sequence_word(afs_pkg::in_item_t w);
    int unsigned n, f, guard;
    longint e, d, t, m, spd;
    afs_pkg::out_item_t r;
    if (w.func == afs_pkg::FuncWrite) begin
      if (w.duration_index < afs_pkg::MaxFrames) durations[w.duration_index] = w.duration_value;
    end else begin
      n = (cfg_count > afs_pkg::MaxFrames) ? afs_pkg::MaxFrames : cfg_count;
      f = cur_frame;
      guard = 0;
      spd = cfg_speed;
      // Clamp the frame to the frames in use before anything else
      if (n == 0) f = 0;
      else if (f >= n) f = n - 1;
      cur_frame = f;
      if (cfg_play && n != 0 && spd != 0) begin
        e = longint'(elapsed_q) + longint'(w.tick_time) * spd;
        if (e > ElapsedMax) e = ElapsedMax;
        if (e < ElapsedMin) e = ElapsedMin;
        if (spd > 0) begin
          while (guard < WalkLimit) begin
            guard++;
            d = dur_fx(f);
            if (d > 0 && e < d) break;
            if (f < n - 1) begin
              if (d > 0) e -= d;
              f++;
            end else if (cfg_loop) begin
              // A zero last frame holds the walk on the last frame
              if (d <= 0) break;
              e -= d;
              f = 0;
              t = pass_fx(n);
              if (t > 0) e = e % t;
            end else begin
              if (d > 0) e = d;
              break;
            end
          end
        end else begin
          while (e < 0 && guard < WalkLimit) begin
            guard++;
            if (f > 0) begin
              f--;
              e += dur_fx(f);
            end else if (cfg_loop) begin
              // A zero first frame holds frame 0, negative time and all
              if (dur_fx(0) <= 0) break;
              f = n - 1;
              e += dur_fx(f);
              t = pass_fx(n);
              if (t > 0 && e < -t) begin
                m = -e;
                e += ((m - 1) / t) * t;
              end
            end else begin
              e = 0;
              break;
            end
          end
        end
        cur_frame = f;
        elapsed_q = int'(e);
      end
    end
    r.frame_index = cur_frame[3:0];
    if (elapsed_q < 0) r.elapsed_time = '0;
    else if ((elapsed_q >>> afs_pkg::FracW) > 65535) r.elapsed_time = '1;
    else r.elapsed_time = afs_pkg::OutTimeW'(elapsed_q >>> afs_pkg::FracW);
    return r;
  endfunction

  // Don't-care fields of each word carry random bits
  function automatic afs_pkg::in_item_t make_write(int idx, int val);
    afs_pkg::in_item_t w;
    w.func = afs_pkg::FuncWrite;
    w.duration_index = 4'(idx);
    w.duration_value = afs_pkg::DurW'(val);
    w.tick_time = afs_pkg::TickW'($urandom);
    return w;
  endfunction

  function automatic afs_pkg::in_item_t make_tick(int tt);
    afs_pkg::in_item_t w;
    w.func = afs_pkg::FuncTick;
    w.duration_index = 4'($urandom);
    w.duration_value = afs_pkg::DurW'($urandom);
    w.tick_time = afs_pkg::TickW'(tt);
    return w;
  endfunction

  function automatic int rand_duration();
    case ($urandom_range(3))
      0: return 0;
      1: return $urandom_range(65535);
      default: return $urandom_range(64, 1);
    endcase
  endfunction

  // Offer one word, hold it until taken, then record what it must yield.
  // Valid is only lowered while idling, so back-to-back words keep it high.
  task automatic send_word(afs_pkg::in_item_t w);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(sequence_word(w));
  endtask

  // Drop valid and wait for every outstanding result before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back; the port never stalls but wait anyway
  task automatic set_mode(int count, bit loop_en, bit play,
                          logic signed [afs_pkg::SpeedW-1:0] spd);
    cfg_index_loop : for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      case (i)
        0: begin
          cfg_index <= afs_pkg::CfgFrameCount;
          cfg_data <= afs_pkg::CfgDataW'(count);
        end
        1: begin
          cfg_index <= afs_pkg::CfgLoopEnable;
          cfg_data <= afs_pkg::CfgDataW'(loop_en);
        end
        2: begin
          cfg_index <= afs_pkg::CfgPlaying;
          cfg_data <= afs_pkg::CfgDataW'(play);
        end
        default: begin
          cfg_index <= afs_pkg::CfgSpeed;
          cfg_data <= spd;
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_count = afs_pkg::CountW'(count);
    cfg_loop = loop_en;
    cfg_play = play;
    cfg_speed = spd;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the flag flips
  always @(posedge clk) begin
    if (hold_flag != hold_seen) begin
      hold_seen <= hold_flag;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  // Compare every taken result word with the oldest outstanding prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding: frame_index %0d elapsed_time %0d",
               out_data.frame_index, out_data.elapsed_time);
        fail_count++;
      end else begin
        want_word = due_results.pop_front();
        if (out_data.frame_index !== want_word.frame_index) begin
          $error("frame_index: expected %0d, got %0d",
                 want_word.frame_index, out_data.frame_index);
          fail_count++;
        end
        if (out_data.elapsed_time !== want_word.elapsed_time) begin
          $error("elapsed_time: expected %0d, got %0d",
                 want_word.elapsed_time, out_data.elapsed_time);
          fail_count++;
        end
      end
    end
  end

  // Straight after reset: no frames and not playing, so a tick only pins frame 0
  task automatic test_reset_idle();
    send_word(make_tick(7));
  endtask

  // Load a short table, including a skipped frame and both value extremes
  task automatic test_table_writes();
    send_word(make_write(0, 2));
    send_word(make_write(1, 0));
    send_word(make_write(2, 3));
    send_word(make_write(3, 1));
    send_word(make_write(15, 65535));
  endtask

  // Forward play: step inside a frame, skip the empty one, wrap, fold whole passes
  task automatic test_forward_wrap();
    settle();
    set_mode(4, 1'b1, 1'b1, 12'sd256);
    send_word(make_tick(1));
    send_word(make_tick(1));
    send_word(make_tick(5));
    send_word(make_tick(65535));
  endtask

  task automatic test_backward_wrap();
    settle();
    set_mode(4, 1'b1, 1'b1, -12'sd256);
    send_word(make_tick(3));
    send_word(make_tick(65535));
  endtask

  // Without looping, stop at the last frame's duration or at zero time
  task automatic test_clamped_ends();
    settle();
    set_mode(4, 1'b0, 1'b1, 12'sd256);
    send_word(make_tick(65535));
    settle();
    set_mode(4, 1'b0, 1'b1, -12'sd2048);
    send_word(make_tick(65535));
  endtask

  // Looping with an empty last frame going forward, then an empty first going back
  task automatic test_zero_end_frames();
    send_word(make_write(3, 0));
    settle();
    set_mode(4, 1'b1, 1'b1, 12'sd2047);
    send_word(make_tick(100));
    send_word(make_write(0, 0));
    settle();
    set_mode(4, 1'b1, 1'b1, -12'sd1);
    send_word(make_tick(65535));
  endtask

  // Paused, and playing at zero speed: time must not move
  task automatic test_paused();
    settle();
    set_mode(4, 1'b1, 1'b0, 12'sd256);
    send_word(make_tick(9));
    settle();
    set_mode(4, 1'b1, 1'b1, 12'sd0);
    send_word(make_tick(9));
  endtask

  // Park on the last frame, then shrink the frame count under it
  task automatic test_frame_clamp();
    settle();
    set_mode(4, 1'b0, 1'b1, 12'sd256);
    send_word(make_tick(65535));
    settle();
    set_mode(2, 1'b0, 1'b0, 12'sd256);
    send_word(make_tick(0));
    settle();
    set_mode(0, 1'b1, 1'b1, 12'sd256);
    send_word(make_tick(40));
  endtask

  // Hold the receiver off long enough that the block backs up into its input
  task automatic test_backpressure();
    settle();
    set_mode(8, 1'b1, 1'b1, 12'sd300);
    hold_flag = !hold_flag;
    repeat (10) send_word(make_tick($urandom_range(120)));
  endtask

  // Random phases: fresh registers each time, then mostly ticks with table rewrites
  task automatic test_random_play();
    int count;
    bit long_ticks;
    logic signed [afs_pkg::SpeedW-1:0] spd;
    // Fill the whole table first so no tick ever reads an unwritten entry
    for (int i = 0; i < afs_pkg::MaxFrames; i++) send_word(make_write(i, rand_duration()));
    for (int ph = 0; ph < 40; ph++) begin
      settle();
      // Run a stretch of phases with no idling on either side
      idle_on = !(ph >= 12 && ph < 18);
      case ($urandom_range(9))
        0: count = 0;
        1: count = $urandom_range(31, 17);
        2: count = afs_pkg::MaxFrames;
        default: count = $urandom_range(afs_pkg::MaxFrames, 1);
      endcase
      case ($urandom_range(6))
        0: spd = 12'sd2047;
        1: spd = -12'sd2048;
        2: spd = 12'sd0;
        default: begin
          spd = afs_pkg::SpeedW'($urandom_range(600, 1));
          if ($urandom_range(1)) spd = -spd;
        end
      endcase
      // Long ticks drive elapsed time into saturation where the ends allow it
      long_ticks = ($urandom_range(6) == 0);
      set_mode(count, 1'($urandom_range(1)), $urandom_range(9) != 0, spd);
      repeat (34) begin
        if ($urandom_range(3) == 0)
          send_word(make_write($urandom_range(afs_pkg::MaxFrames - 1), rand_duration()));
        else if (long_ticks)
          send_word(make_tick($urandom_range(65535, 60000)));
        else if ($urandom_range(19) == 0)
          send_word(make_tick($urandom_range(65535)));
        else
          send_word(make_tick($urandom_range(150)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_idle();
    test_table_writes();
    test_forward_wrap();
    test_backward_wrap();
    test_clamped_ends();
    test_zero_end_frames();
    test_paused();
    test_frame_clamp();
    test_random_play();
    test_backpressure();
    settle();
    // Leave room for any stray result word to show up
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
